/* sv/att_pkg.sv */
// ----------------------------------------------------------------------------
// att_pkg: shared types and constants of the allocation tracking table
// Event codes, status codes, the control word that walks the cell chain and
// the layout of the result word.
// ----------------------------------------------------------------------------
package att_pkg;

  // default sizes of the table and its fields
  localparam int ENTRIES_DEF    = 64;
  localparam int ADDR_BITS_DEF  = 48;
  localparam int SIZE_BITS_DEF  = 32;

  // a block size never takes more than this many bits
  localparam int MAX_SIZE_W     = 32;

  // result field widths
  localparam int SLOT_W         = 6;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 32;
  localparam int BYTES_W        = 48;

  // result word layout, lowest field first
  localparam int ALLOC_LSB      = SLOT_W;
  localparam int FREE_LSB       = ALLOC_LSB + COUNT_W;
  localparam int CUR_LSB        = FREE_LSB + COUNT_W;
  localparam int PEAK_LSB       = CUR_LSB + BYTES_W;
  localparam int OUT_FIELDS_W   = PEAK_LSB + BYTES_W;
  localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } act_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_e_t;

  // control word carried from cell to cell with each event
  typedef struct packed {
    logic               vld;   // stage holds an event
    act_e_t             act;   // allocation or free
    logic               nul;   // free of address zero
    logic               done;  // a cell has claimed the event
    logic [SLOT_W-1:0]  slot;  // claiming cell, low bits of its index
  } att_ctl_t;

endpackage

/* sv/allocation_tracking_table.sv */
// ----------------------------------------------------------------------------
// allocation_tracking_table: allocation event monitor with slot table
// Records allocations in a table of slots and matches frees against it,
// keeping saturating counts, outstanding bytes and the peak.
// ----------------------------------------------------------------------------
// Each event enters a chain of ENTRIES cells, one slot per cell, and moves one
// cell per cycle while the chain advances; the first empty cell takes an
// allocation, the first valid cell with the same address clears on a free.
// While the chain is not frozen, one word is taken per cycle. The event is
// registered in the first cell when taken, then in each further cell, and
// last in the counter stage, which holds the result. A stalled result
// freezes the whole chain only when an event has reached its end. Slot
// numbers above 63 report their low six bits.
// ----------------------------------------------------------------------------
module allocation_tracking_table #(
  parameter int ENTRIES      = att_pkg::ENTRIES_DEF,
  parameter int ADDRESS_BITS = att_pkg::ADDR_BITS_DEF,
  parameter int SIZE_BITS    = att_pkg::SIZE_BITS_DEF,
  localparam int IN_DATA_W   = ((ADDRESS_BITS + SIZE_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DATA_W-1:0]             in_tdata,  // address, block_size
  input  logic                             in_tuser,  // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [att_pkg::OUT_DATA_W-1:0]   out_tdata, // slot, alloc_count,
                                                      // free_count, current_bytes,
                                                      // peak_bytes
  output logic [att_pkg::STATUS_W-1:0]     out_tuser  // status
);
  import att_pkg::*;

  localparam int SZ_W = (SIZE_BITS < MAX_SIZE_W) ? SIZE_BITS : MAX_SIZE_W;

  att_ctl_t                ctl  [0:ENTRIES];
  logic [ADDRESS_BITS-1:0] addr [0:ENTRIES];
  logic [SZ_W-1:0]         size [0:ENTRIES];

  logic                    adv;
  status_e_t               status;
  logic [SLOT_W-1:0]       slot;
  logic [COUNT_W-1:0]      alloc_count, free_count;
  logic [BYTES_W-1:0]      current_bytes, peak_bytes;

  // chain moves unless a finished event waits on a stalled result
  assign adv       = !(ctl[ENTRIES].vld && out_tvalid && !out_tready);
  assign in_tready = adv;

  // launch the incoming word; a free of address zero is settled here
  always_comb begin
    addr[0]     = in_tdata[ADDRESS_BITS-1:0];
    size[0]     = in_tdata[ADDRESS_BITS +: SZ_W];
    ctl[0].vld  = in_tvalid;
    ctl[0].act  = act_e_t'(in_tuser);
    ctl[0].nul  = (act_e_t'(in_tuser) == ACT_FREE) && (addr[0] == '0);
    ctl[0].done = ctl[0].nul;
    ctl[0].slot = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    att_cell #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .SZ_W         (SZ_W),
      .SLOT_ID      (SLOT_W'(g))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (ctl[g]),
      .addr_i (addr[g]),
      .size_i (size[g]),
      .ctl_o  (ctl[g+1]),
      .addr_o (addr[g+1]),
      .size_o (size[g+1])
    );
  end

  att_tally #(
    .SZ_W (SZ_W)
  ) u_tally (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .ctl_i         (ctl[ENTRIES]),
    .size_i        (size[ENTRIES]),
    .out_rdy       (out_tready),
    .out_vld       (out_tvalid),
    .status        (status),
    .slot          (slot),
    .alloc_count   (alloc_count),
    .free_count    (free_count),
    .current_bytes (current_bytes),
    .peak_bytes    (peak_bytes)
  );

  // pack the result word
  assign out_tdata = OUT_DATA_W'({peak_bytes, current_bytes, free_count,
                                  alloc_count, slot});
  assign out_tuser = status;

endmodule

/* sv/att_cell.sv */
// ----------------------------------------------------------------------------
// att_cell: one table entry and one stage of the event chain
// Holds one slot (address, size, valid). Each event passing through may claim
// the slot: an allocation takes it if empty, a free clears it on an address
// match. The event is registered here and then moves on to the next cell.
// ----------------------------------------------------------------------------
module att_cell #(
  parameter int                      ADDRESS_BITS = att_pkg::ADDR_BITS_DEF,
  parameter int                      SZ_W         = att_pkg::MAX_SIZE_W,
  parameter logic [att_pkg::SLOT_W-1:0] SLOT_ID   = '0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  att_pkg::att_ctl_t       ctl_i,
  input  logic [ADDRESS_BITS-1:0] addr_i,
  input  logic [SZ_W-1:0]         size_i,
  output att_pkg::att_ctl_t       ctl_o,
  output logic [ADDRESS_BITS-1:0] addr_o,
  output logic [SZ_W-1:0]         size_o
);
  import att_pkg::*;

  logic                    ent_vld_r;
  logic [ADDRESS_BITS-1:0] ent_addr_r;
  logic [SZ_W-1:0]         ent_size_r;

  att_ctl_t                ctl_r, ctl_nxt;
  logic [ADDRESS_BITS-1:0] addr_r;
  logic [SZ_W-1:0]         size_r, size_nxt;

  logic take, hit;

  // claim the slot: empty slot for an allocation, matching slot for a free
  always_comb begin
    take = ctl_i.vld && !ctl_i.done && (ctl_i.act == ACT_ALLOC) && !ent_vld_r;
    hit  = ctl_i.vld && !ctl_i.done && (ctl_i.act == ACT_FREE) && ent_vld_r &&
           (ent_addr_r == addr_i);
  end

  // mark the event claimed; a matched free carries the slot's size onward
  always_comb begin
    ctl_nxt  = ctl_i;
    size_nxt = size_i;
    if (take || hit) begin
      ctl_nxt.done = 1'b1;
      ctl_nxt.slot = SLOT_ID;
    end
    if (hit) begin
      size_nxt = ent_size_r;
    end
  end

  // advance the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr_r <= addr_i;
      size_r <= size_nxt;
    end
  end

  // update the entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (adv && take) begin
      ent_vld_r <= 1'b1;
    end else if (adv && hit) begin
      ent_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      ent_addr_r <= addr_i;
      ent_size_r <= size_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign addr_o = addr_r;
  assign size_o = size_r;

endmodule

/* sv/att_tally.sv */
// ----------------------------------------------------------------------------
// att_tally: event counters and result register
// Takes each event from the end of the cell chain, updates the saturating
// allocation, free and byte counters and the peak, and holds the result word
// until the sink takes it.
// ----------------------------------------------------------------------------
module att_tally #(
  parameter int SZ_W = att_pkg::MAX_SIZE_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  att_pkg::att_ctl_t           ctl_i,
  input  logic [SZ_W-1:0]             size_i,
  input  logic                        out_rdy,
  output logic                        out_vld,
  output att_pkg::status_e_t          status,
  output logic [att_pkg::SLOT_W-1:0]  slot,
  output logic [att_pkg::COUNT_W-1:0] alloc_count,
  output logic [att_pkg::COUNT_W-1:0] free_count,
  output logic [att_pkg::BYTES_W-1:0] current_bytes,
  output logic [att_pkg::BYTES_W-1:0] peak_bytes
);
  import att_pkg::*;

  logic                 out_vld_r;
  status_e_t            status_r, status_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [COUNT_W-1:0]   allocs_r, allocs_nxt;
  logic [COUNT_W-1:0]   frees_r, frees_nxt;
  logic [BYTES_W-1:0]   cur_r, cur_nxt;
  logic [BYTES_W-1:0]   peak_r, peak_nxt;
  logic [BYTES_W-1:0]   size_ext;
  logic [BYTES_W:0]     sum;
  logic                 load;

  assign load     = adv && ctl_i.vld;
  assign size_ext = BYTES_W'(size_i);
  assign sum      = {1'b0, cur_r} + {1'b0, size_ext};

  // status and slot of the event
  always_comb begin
    status_nxt = ST_OK;
    if (ctl_i.act == ACT_ALLOC) begin
      status_nxt = ctl_i.done ? ST_OK : ST_FULL;
    end else if (ctl_i.nul) begin
      status_nxt = ST_NULL;
    end else if (!ctl_i.done) begin
      status_nxt = ST_UNKNOWN;
    end
    slot_nxt = (status_nxt == ST_OK) ? ctl_i.slot : '0;
  end

  // saturating counter updates
  always_comb begin
    allocs_nxt = allocs_r;
    frees_nxt  = frees_r;
    cur_nxt    = cur_r;
    if (ctl_i.act == ACT_ALLOC) begin
      allocs_nxt = (allocs_r == COUNT_MAX) ? allocs_r : allocs_r + 1'b1;
      cur_nxt    = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
    end else if (ctl_i.done && !ctl_i.nul) begin
      frees_nxt  = (frees_r == COUNT_MAX) ? frees_r : frees_r + 1'b1;
      cur_nxt    = (size_ext >= cur_r) ? '0 : cur_r - size_ext;
    end
    peak_nxt = (cur_nxt > peak_r) ? cur_nxt : peak_r;
  end

  // hold counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allocs_r <= '0;
      frees_r  <= '0;
      cur_r    <= '0;
      peak_r   <= '0;
    end else if (load) begin
      allocs_r <= allocs_nxt;
      frees_r  <= frees_nxt;
      cur_r    <= cur_nxt;
      peak_r   <= peak_nxt;
    end
  end

  // result word valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
    end
  end

  assign out_vld       = out_vld_r;
  assign status        = status_r;
  assign slot          = slot_r;
  assign alloc_count   = allocs_r;
  assign free_count    = frees_r;
  assign current_bytes = cur_r;
  assign peak_bytes    = peak_r;

endmodule

/* sv/att_checker.sv */
// ----------------------------------------------------------------------------
// att_checker: port-level checks of the allocation tracking table
// Watches the result channel for handshake and consistency problems.
// ----------------------------------------------------------------------------
module att_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [att_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [att_pkg::STATUS_W-1:0]   out_tuser
);
  import att_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser))
    else $error("result word changed while stalled");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // failed events report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata[SLOT_W-1:0] == '0)
    else $error("nonzero slot on failed event");

  // peak never below the outstanding total
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[PEAK_LSB +: BYTES_W] >= out_tdata[CUR_LSB +: BYTES_W])
    else $error("peak below outstanding bytes");

  // allocation count never drops between taken results
  a_alloc_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid |->
    out_tdata[ALLOC_LSB +: COUNT_W] >= $past(out_tdata[ALLOC_LSB +: COUNT_W]))
    else $error("allocation count decreased");

endmodule

bind allocation_tracking_table att_checker u_att_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the allocation tracking table
// Drives allocation and free words with random idling on both sides, predicts
// each result word from a behavioral copy of the slot table or a typed row and
// compares the words field by field in arrival order. A directed table comes
// first, then random traffic, then a run of maximum-size allocations without
// idling that overfills the table, followed by frees and refills.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import att_pkg::*;

  localparam int N_SLOTS    = ENTRIES_DEF;
  localparam int ADDR_W     = ADDR_BITS_DEF;
  localparam int SZ_W       = SIZE_BITS_DEF;
  localparam int IN_W       = ((ADDR_W + SZ_W + 7) / 8) * 8;
  localparam int CYCLE_CAP  = 200_000;
  localparam int RAND_WORDS = 800;
  localparam int FILL_WORDS = 72;

  typedef struct packed {
    status_e_t            status;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   alloc_count;
    logic [COUNT_W-1:0]   free_count;
    logic [BYTES_W-1:0]   cur_bytes;
    logic [BYTES_W-1:0]   peak_bytes;
  } att_result_t;

  typedef struct packed {
    act_e_t               act;
    logic [ADDR_W-1:0]    addr;
    logic [SZ_W-1:0]      size;
    logic                 typed;  // res holds a hand-written expectation
    att_result_t          res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata;   // address, block_size
  logic                   in_tuser;   // action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;  // slot, alloc_count, free_count,
                                      // current_bytes, peak_bytes
  logic [STATUS_W-1:0]    out_tuser;  // status

  // shadow copy of the slot table and counters
  logic [ADDR_W-1:0]      slot_addr [N_SLOTS];
  logic [SZ_W-1:0]        slot_size [N_SLOTS];
  bit                     slot_valid [N_SLOTS];
  logic [COUNT_W-1:0]     alloc_total;
  logic [COUNT_W-1:0]     free_total;
  logic [BYTES_W-1:0]     bytes_out;
  logic [BYTES_W-1:0]     bytes_peak;

  att_result_t            pending_results [$];
  logic [ADDR_W-1:0]      live_addrs [$];
  stim_row_t              dir_rows [$];
  bit                     row_typed;
  att_result_t            row_res;
  bit                     idle_on;
  int                     rx_hold;
  int                     fails;
  int                     cycle_cnt;

  allocation_tracking_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the shadow table by one event and return the word it causes
  function automatic att_result_t track_event(act_e_t act, logic [ADDR_W-1:0] addr,
                                              logic [SZ_W-1:0] size);
    att_result_t r;
    bit hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    if (act == ACT_ALLOC) begin
      if (alloc_total != COUNT_MAX) alloc_total = alloc_total + 1'b1;
      if (BYTES_MAX - bytes_out <= BYTES_W'(size)) bytes_out = BYTES_MAX;
      else bytes_out = bytes_out + BYTES_W'(size);
      if (bytes_out > bytes_peak) bytes_peak = bytes_out;
      // take the lowest empty slot
      for (int i = 0; i < N_SLOTS && !hit; i++) begin
        if (!slot_valid[i]) begin
          slot_addr[i]  = addr;
          slot_size[i]  = size;
          slot_valid[i] = 1'b1;
          r.slot = SLOT_W'(i);
          hit = 1'b1;
        end
      end
      if (!hit) r.status = ST_FULL;
    end else if (addr == '0) begin
      r.status = ST_NULL;
    end else begin
      // clear the lowest valid slot holding this address
      for (int i = 0; i < N_SLOTS && !hit; i++) begin
        if (slot_valid[i] && slot_addr[i] == addr) begin
          if (BYTES_W'(slot_size[i]) >= bytes_out) bytes_out = '0;
          else bytes_out = bytes_out - BYTES_W'(slot_size[i]);
          if (free_total != COUNT_MAX) free_total = free_total + 1'b1;
          slot_valid[i] = 1'b0;
          r.slot = SLOT_W'(i);
          hit = 1'b1;
        end
      end
      if (!hit) r.status = ST_UNKNOWN;
    end
    r.alloc_count = alloc_total;
    r.free_count  = free_total;
    r.cur_bytes   = bytes_out;
    r.peak_bytes  = bytes_peak;
    return r;
  endfunction

  // compare one result word against its expectation
  task automatic check_result(att_result_t want);
    if (out_tuser !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, out_tuser);
      fails++;
    end
    if (out_tdata[SLOT_W-1:0] !== want.slot) begin
      $error("slot: expected %0d, actual %0d", want.slot, out_tdata[SLOT_W-1:0]);
      fails++;
    end
    if (out_tdata[ALLOC_LSB +: COUNT_W] !== want.alloc_count) begin
      $error("alloc_count: expected %0d, actual %0d", want.alloc_count,
             out_tdata[ALLOC_LSB +: COUNT_W]);
      fails++;
    end
    if (out_tdata[FREE_LSB +: COUNT_W] !== want.free_count) begin
      $error("free_count: expected %0d, actual %0d", want.free_count,
             out_tdata[FREE_LSB +: COUNT_W]);
      fails++;
    end
    if (out_tdata[CUR_LSB +: BYTES_W] !== want.cur_bytes) begin
      $error("current_bytes: expected %h, actual %h", want.cur_bytes,
             out_tdata[CUR_LSB +: BYTES_W]);
      fails++;
    end
    if (out_tdata[PEAK_LSB +: BYTES_W] !== want.peak_bytes) begin
      $error("peak_bytes: expected %h, actual %h", want.peak_bytes,
             out_tdata[PEAK_LSB +: BYTES_W]);
      fails++;
    end
  endtask

  // check result words and predict each accepted input word
  always @(posedge clk) begin : scoreboard
    att_result_t pred;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word with none pending, status %0d", out_tuser);
          fails++;
        end else begin
          check_result(pending_results.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        pred = track_event(act_e_t'(in_tuser), in_tdata[ADDR_W-1:0],
                           in_tdata[ADDR_W +: SZ_W]);
        pending_results.push_back(row_typed ? row_res : pred);
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int idle_left;
    idle_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (idle_left > 0) begin
        out_tready <= 1'b0;
        idle_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        idle_left = $urandom_range(0, 7);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // give up on a hung run
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // offer one word and hold it until accepted
  task automatic offer_word(act_e_t act, logic [ADDR_W-1:0] addr, logic [SZ_W-1:0] size,
                            bit typed, att_result_t res);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_W'({size, addr});
    row_typed = typed;
    row_res   = res;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid for a random burst now and then
  task automatic sender_idle();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
  endtask

  // stop offering and wait for every pending result word
  task automatic drain_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // random traffic: phases that fill or drain the table, with live frees
  task automatic random_run(int count);
    int alloc_pct;
    int idx;
    act_e_t act;
    logic [ADDR_W-1:0] a;
    logic [SZ_W-1:0] s;
    alloc_pct = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: alloc_pct = 20;
          1: alloc_pct = 50;
          default: alloc_pct = 85;
        endcase
      end
      if (k == count / 2) rx_hold = 300;
      if (k % 300 == 299) drain_input();
      if ($urandom_range(0, 99) < alloc_pct) begin
        act = ACT_ALLOC;
        case ($urandom_range(0, 9))
          0: a = ADDR_W'($urandom_range(1, 6));
          1: a = (live_addrs.size() != 0) ?
                 live_addrs[$urandom_range(0, live_addrs.size() - 1)] : rand_addr();
          default: a = rand_addr();
        endcase
        case ($urandom_range(0, 7))
          0: s = '0;
          1: s = '1;
          2: s = SZ_W'($urandom_range(1, 4096));
          default: s = $urandom;
        endcase
        if (live_addrs.size() < 256) live_addrs.push_back(a);
      end else begin
        act = ACT_FREE;
        s = $urandom;
        idx = $urandom_range(0, 9);
        if (idx == 0) begin
          a = '0;
        end else if (idx < 3 || live_addrs.size() == 0) begin
          a = rand_addr();
        end else begin
          idx = $urandom_range(0, live_addrs.size() - 1);
          a = live_addrs[idx];
          live_addrs.delete(idx);
        end
      end
      sender_idle();
      offer_word(act, a, s, 1'b0, '0);
    end
  endtask

  // build the directed table; hand-typed results only where obvious
  task automatic build_dir_rows();
    dir_rows.push_back('{ACT_ALLOC, 48'h0000_0000_1000, 32'd100, 1'b1,
                         '{ST_OK, 6'd0, 32'd1, 32'd0, 48'd100, 48'd100}});
    dir_rows.push_back('{ACT_FREE, 48'h0, 32'hFFFF_FFFF, 1'b1,
                         '{ST_NULL, 6'd0, 32'd1, 32'd0, 48'd100, 48'd100}});
    dir_rows.push_back('{ACT_FREE, 48'h0000_DEAD_BEEF, 32'd0, 1'b1,
                         '{ST_UNKNOWN, 6'd0, 32'd1, 32'd0, 48'd100, 48'd100}});
    dir_rows.push_back('{ACT_ALLOC, 48'h0, 32'd0, 1'b1,
                         '{ST_OK, 6'd1, 32'd2, 32'd0, 48'd100, 48'd100}});
    dir_rows.push_back('{ACT_FREE, 48'h0000_0000_1000, 32'd0, 1'b1,
                         '{ST_OK, 6'd0, 32'd2, 32'd1, 48'd0, 48'd100}});
    dir_rows.push_back('{ACT_ALLOC, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                         '{ST_OK, 6'd0, 32'd3, 32'd1, 48'hFFFF_FFFF, 48'hFFFF_FFFF}});
    // duplicate address, then frees that peel off the lowest match first
    dir_rows.push_back('{ACT_ALLOC, 48'hFFFF_FFFF_FFFF, 32'd1, 1'b0, '0});
    dir_rows.push_back('{ACT_ALLOC, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0, '0});
    dir_rows.push_back('{ACT_ALLOC, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, '0});
    // a recorded zero address is never matched
    dir_rows.push_back('{ACT_FREE, 48'h0, 32'd0, 1'b0, '0});
    dir_rows.push_back('{ACT_ALLOC, 48'h0000_0000_0001, 32'd1, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'h5555_5555_5555, 32'hFFFF_FFFF, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'hAAAA_AAAA_AAAA, 32'd0, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'h0000_0000_0001, 32'd0, 1'b0, '0});
    dir_rows.push_back('{ACT_ALLOC, 48'h8000_0000_0000, 32'h8000_0000, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'h8000_0000_0000, 32'd0, 1'b0, '0});
    dir_rows.push_back('{ACT_FREE, 48'h0000_0000_0001, 32'd0, 1'b0, '0});
  endtask

  // main sequence
  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_ALLOC;
    row_typed = 1'b0;
    row_res   = '0;
    idle_on   = 1'b1;
    rx_hold   = 0;
    fails     = 0;
    alloc_total = '0;
    free_total  = '0;
    bytes_out   = '0;
    bytes_peak  = '0;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    build_dir_rows();
    foreach (dir_rows[i]) begin
      sender_idle();
      offer_word(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].size,
                 dir_rows[i].typed, dir_rows[i].res);
    end
    drain_input();

    random_run(RAND_WORDS);
    drain_input();

    // final stretch without idling: overfill the table, then free and refill
    idle_on = 1'b0;
    for (int k = 0; k < FILL_WORDS; k++) offer_word(ACT_ALLOC, rand_addr(), '1, 1'b0, '0);
    for (int k = 0; k < 8; k++) begin
      offer_word(ACT_FREE, (live_addrs.size() != 0) ? live_addrs.pop_front() : rand_addr(),
                 '0, 1'b0, '0);
    end
    for (int k = 0; k < 8; k++) offer_word(ACT_ALLOC, rand_addr(), $urandom, 1'b0, '0);
    drain_input();

    repeat (2 * N_SLOTS + 10) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
